[design/tfcp_pkg.sv]
// ----------------------------------------------------------------------------
// tfcp_pkg
// Shared types, register codes and the throttle level table of the thermal
// frequency cap policy.
// ----------------------------------------------------------------------------
package tfcp_pkg;

  localparam int TempW   = 9;
  localparam int ThrW    = 8;
  localparam int TickW   = 16;
  localparam int CapW    = 32;
  localparam int HoldW   = 16;
  localparam int MarginW = 5;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  // Rows checked per sample; slots past the table repeat the last row.
  localparam int NumLevels  = 5;
  localparam int LevelSlots = 8;
  localparam int LevelIdxW  = $clog2(LevelSlots);

  typedef logic signed [TempW-1:0] temp_t;
  typedef logic [ThrW-1:0]         thr_t;
  typedef logic [TickW-1:0]        tick_t;
  typedef logic [CapW-1:0]         cap_t;
  typedef logic [HoldW-1:0]        hold_t;
  typedef logic [MarginW-1:0]      margin_t;
  typedef logic [CfgIdxW-1:0]      cfg_idx_t;
  typedef logic [CfgDataW-1:0]     cfg_data_t;

  localparam cap_t CapUnlimited = '1;

  localparam cfg_idx_t CFG_BASE_TEMP = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_TICK_MS   = cfg_idx_t'(1);

  localparam thr_t  ThrReset  = thr_t'(70);
  localparam tick_t TickReset = tick_t'(500);

  // Policy state carried from sample to sample.
  typedef struct packed {
    cap_t  cap;
    hold_t hold;
    logic  throttle;
  } tfcp_state_t;

  typedef struct packed {
    margin_t margin;
    cap_t    cap;
    hold_t   hold;
  } level_row_t;

  function automatic level_row_t level_row(input logic [LevelIdxW-1:0] idx);
    level_row_t r;
    case (idx)
      3'd0:    r = '{margin: margin_t'(15), cap: cap_t'(729600),  hold: hold_t'(4000)};
      3'd1:    r = '{margin: margin_t'(12), cap: cap_t'(1190400), hold: hold_t'(3000)};
      3'd2:    r = '{margin: margin_t'(9),  cap: cap_t'(1497600), hold: hold_t'(3000)};
      3'd3:    r = '{margin: margin_t'(5),  cap: cap_t'(1728000), hold: hold_t'(2000)};
      default: r = '{margin: margin_t'(0),  cap: cap_t'(1958400), hold: hold_t'(2000)};
    endcase
    return r;
  endfunction

endpackage

[design/tfcp_in_if.sv]
// ----------------------------------------------------------------------------
// tfcp_in_if
// Sample channel: valid/ready handshake carrying one temperature item.
// ----------------------------------------------------------------------------
interface tfcp_in_if;
  logic                valid;
  logic                ready;
  tfcp_pkg::temp_t     temperature;

  modport source (output valid, output temperature, input ready);
  modport sink   (input valid, input temperature, output ready);
endinterface

[design/tfcp_out_if.sv]
// ----------------------------------------------------------------------------
// tfcp_out_if
// Result channel: valid/ready handshake carrying cap, change and throttle flag.
// ----------------------------------------------------------------------------
interface tfcp_out_if;
  logic            valid;
  logic            ready;
  tfcp_pkg::cap_t  freq_cap_khz;
  logic            cap_changed;
  logic            is_throttling;

  modport source (output valid, output freq_cap_khz, output cap_changed,
                  output is_throttling, input ready);
  modport sink   (input valid, input freq_cap_khz, input cap_changed,
                  input is_throttling, output ready);
endinterface

[design/thermal_frequency_cap_policy.sv]
// ----------------------------------------------------------------------------
// thermal_frequency_cap_policy
// Per-sample CPU frequency cap policy with throttle levels and hold time.
// ----------------------------------------------------------------------------
//
//   channel     dir   handshake     payload
//   ---------   ---   -----------   ------------------------------------------
//   sample_ch   in    valid/ready   temperature (9b signed, deg C)
//   result_ch   out   valid/ready   freq_cap_khz (32b), cap_changed, is_throttling
//   cfg         in    cfg_we        cfg_index (0 threshold, 1 tick), cfg_wdata
//
// One item per cycle sustained while result_ch.ready stays high. An accepted
// item passes an input register, then the policy step into the result
// register, which drives result_ch.valid; the policy state updates in the
// same cycle as the step.
// Reset (rst, synchronous) empties both stages and restores the cap to
// unlimited, hold to zero, not throttling, threshold 70 and tick 500.
// A stalled result holds its register; one further item waits in the input
// register, after which sample_ch.ready drops.
// ----------------------------------------------------------------------------
module thermal_frequency_cap_policy (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  tfcp_pkg::cfg_idx_t   cfg_index,
  input  tfcp_pkg::cfg_data_t  cfg_wdata,
  tfcp_in_if.sink              sample_ch,
  tfcp_out_if.source           result_ch
);
  import tfcp_pkg::*;

  // Configuration registers
  thr_t        base_temp;
  tick_t       tick_ms;

  // Input stage
  logic        s1_valid;
  temp_t       s1_temp;

  // Policy state
  tfcp_state_t state;
  tfcp_state_t state_next;
  logic        changed;

  // Result stage
  logic        out_valid;
  cap_t        out_cap;
  logic        out_changed;
  logic        out_throttle;

  logic        advance;

  // Step the held sample whenever the result register is free or draining.
  assign advance         = s1_valid && (!out_valid || result_ch.ready);
  assign sample_ch.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_temp <= ThrReset;
      tick_ms   <= TickReset;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE_TEMP) begin
        base_temp <= cfg_wdata[ThrW-1:0];
      end else if (cfg_index == CFG_TICK_MS) begin
        tick_ms <= cfg_wdata[TickW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_ch.valid && sample_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ch.valid && sample_ch.ready) begin
      s1_temp <= sample_ch.temperature;
    end
  end

  tfcp_decide u_decide (
    .temperature (s1_temp),
    .base_temp   (base_temp),
    .tick_ms     (tick_ms),
    .cur         (state),
    .nxt         (state_next),
    .changed     (changed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{cap: CapUnlimited, hold: '0, throttle: 1'b0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_cap      <= state_next.cap;
      out_changed  <= changed;
      out_throttle <= state_next.throttle;
    end
  end

  assign result_ch.valid         = out_valid;
  assign result_ch.freq_cap_khz  = out_cap;
  assign result_ch.cap_changed   = out_changed;
  assign result_ch.is_throttling = out_throttle;

endmodule

[design/tfcp_decide.sv]
// ----------------------------------------------------------------------------
// tfcp_decide
// Combinational policy step: release check, level match, hold countdown and
// cap update for one sample.
// ----------------------------------------------------------------------------
module tfcp_decide (
  input  tfcp_pkg::temp_t       temperature,
  input  tfcp_pkg::thr_t        base_temp,
  input  tfcp_pkg::tick_t       tick_ms,
  input  tfcp_pkg::tfcp_state_t cur,
  output tfcp_pkg::tfcp_state_t nxt,
  output logic                  changed
);
  import tfcp_pkg::*;

  logic signed [TempW:0] temp_ext;
  logic signed [TempW:0] thr_ext;
  logic signed [TempW:0] limit [LevelSlots];
  level_row_t            rows [LevelSlots];
  logic [LevelSlots-1:0] hit;
  logic                  any_hit;
  level_row_t            sel_row;
  logic                  release_req;
  logic                  attempt;
  cap_t                  new_cap;
  hold_t                 new_hold;
  hold_t                 hold_dec;
  logic                  refused;

  assign temp_ext = {temperature[TempW-1], temperature};
  assign thr_ext  = {{(TempW+1-ThrW){1'b0}}, base_temp};

  // Parallel compares against threshold plus each level's margin.
  always_comb begin
    for (int i = 0; i < LevelSlots; i++) begin
      rows[i]  = level_row(LevelIdxW'(i));
      limit[i] = thr_ext + $signed({{(TempW+1-MarginW){1'b0}}, rows[i].margin});
      hit[i]   = (i < NumLevels) && (temp_ext > limit[i]);
    end
  end

  // First matching level wins.
  always_comb begin
    sel_row = rows[0];
    for (int i = LevelSlots - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel_row = rows[i];
      end
    end
  end

  assign any_hit     = |hit;
  assign release_req = cur.throttle && (temp_ext < thr_ext);
  assign attempt     = release_req || any_hit;
  assign new_cap     = release_req ? CapUnlimited : sel_row.cap;
  assign new_hold    = release_req ? '0 : sel_row.hold;

  // Saturating countdown, applied on every refused attempt.
  assign hold_dec = (cur.hold < tick_ms) ? '0 : (cur.hold - tick_ms);

  // Raise blocked while hold remains; same cap is refused and only counts the hold down.
  assign refused = ((cur.cap < new_cap) && (hold_dec != '0)) || (cur.cap == new_cap);
  assign changed = attempt && !refused;

  always_comb begin
    nxt = cur;
    if (attempt) begin
      if (refused) begin
        nxt.hold = hold_dec;
      end else begin
        nxt.cap  = new_cap;
        nxt.hold = new_hold;
      end
    end
    if (release_req) begin
      nxt.throttle = !changed;
    end else if (any_hit) begin
      nxt.throttle = 1'b1;
    end
  end

endmodule

[design/tfcp_checker.sv]
// ----------------------------------------------------------------------------
// tfcp_checker
// Port-level checks for the thermal frequency cap policy, bound to the top.
// ----------------------------------------------------------------------------
module tfcp_checker (
  input logic           clk,
  input logic           rst,
  input logic           sample_ready,
  input logic           result_valid,
  input logic           result_ready,
  input tfcp_pkg::cap_t freq_cap_khz,
  input logic           cap_changed,
  input logic           is_throttling
);
  import tfcp_pkg::*;

  // Pipeline empties on reset.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> (!result_valid && sample_ready))
    else $error("pipeline not empty after reset");

  // Throttling exactly when a finite cap is in force.
  a_throttle_cap : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (is_throttling == (freq_cap_khz != CapUnlimited)))
    else $error("throttle flag disagrees with cap");

  // A change to unlimited must end throttling.
  a_release : assert property (@(posedge clk) disable iff (rst)
    (result_valid && cap_changed && (freq_cap_khz == CapUnlimited)) |-> !is_throttling)
    else $error("released cap while still throttling");

  // Stalled result holds.
  a_hold : assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(freq_cap_khz) && $stable(cap_changed)
       && $stable(is_throttling)))
    else $error("stalled result changed");

endmodule

bind thermal_frequency_cap_policy tfcp_checker u_tfcp_checker (
  .clk           (clk),
  .rst           (rst),
  .sample_ready  (sample_ch.ready),
  .result_valid  (result_ch.valid),
  .result_ready  (result_ch.ready),
  .freq_cap_khz  (result_ch.freq_cap_khz),
  .cap_changed   (result_ch.cap_changed),
  .is_throttling (result_ch.is_throttling)
);
